@@ hdl/lsfb_pkg.sv @@
// Shared types and constants for the LED strip frame buffer.
`timescale 1ns / 1ps
`default_nettype none

package lsfb_pkg;

  localparam int unsigned MAX_LEDS_DEF = 32;
  localparam int unsigned LED_W        = 29;  // level[28:24] blue[23:16] green[15:8] red[7:0]
  localparam int unsigned LVL_W        = 5;
  localparam int unsigned COL_W        = 8;
  localparam int unsigned IDX_IN_W     = 6;
  localparam int unsigned CFG_CNT_W    = 6;
  localparam int unsigned WORD_W       = 32;
  localparam int unsigned ENDS_SHIFT   = 6;   // end words grow by one per 64 LEDs

  localparam logic [CFG_CNT_W-1:0] LED_COUNT_RST = 6'd32;
  localparam logic [2:0]           LED_HDR       = 3'b111;

  localparam logic REG_LED_COUNT = 1'b0;
  localparam logic REG_OUT_EN    = 1'b1;

  typedef enum logic [2:0] {
    REQ_SET_ONE  = 3'd0,
    REQ_SET_ALL  = 3'd1,
    REQ_DIM      = 3'd2,
    REQ_ROT_LEFT = 3'd3,
    REQ_ROT_RGHT = 3'd4,
    REQ_UNROTATE = 3'd5,
    REQ_FLUSH    = 3'd6
  } req_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_DISABLED = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    HEAD_PASS = 2'd0,
    HEAD_LOAD = 2'd1,
    HEAD_DIM  = 2'd2
  } head_op_e;

  typedef struct packed {
    head_op_e          op;
    logic [LVL_W-1:0]  level;
    logic [COL_W-1:0]  blue;
    logic [COL_W-1:0]  green;
    logic [COL_W-1:0]  red;
    logic [COL_W-1:0]  dim_step;
  } head_ctrl_t;

endpackage

`default_nettype wire

@@ hdl/lsfb_cell.sv @@
// One LED slot of the shift ring.
`timescale 1ns / 1ps
`default_nettype none

module lsfb_cell
  import lsfb_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             shift_i,
  input  wire logic             active_i,
  input  wire logic             tail_i,
  input  wire logic [LED_W-1:0] nbr_i,
  input  wire logic [LED_W-1:0] wrap_i,
  output logic      [LED_W-1:0] q_o
);

  logic [LED_W-1:0] slot_q, slot_d;

  always_comb begin
    slot_d = slot_q;
    if (shift_i && active_i) begin
      slot_d = tail_i ? wrap_i : nbr_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else begin
      slot_q <= slot_d;
    end
  end

  assign q_o = slot_q;

endmodule

`default_nettype wire

@@ hdl/lsfb_head.sv @@
// Edit unit at the ring head: load, dim or pass the slot leaving cell 0.
`timescale 1ns / 1ps
`default_nettype none

module lsfb_head
  import lsfb_pkg::*;
(
  input  wire logic [LED_W-1:0] cur_i,
  input  wire head_ctrl_t       ctrl_i,
  output logic      [LED_W-1:0] nxt_o
);

  logic [LVL_W-1:0] cur_lvl;
  logic [LVL_W-1:0] dim_lvl;

  assign cur_lvl = cur_i[LED_W-1 -: LVL_W];

  // saturating subtract, floor at zero
  assign dim_lvl = ({3'b000, cur_lvl} < ctrl_i.dim_step) ? '0
                 : LVL_W'({3'b000, cur_lvl} - ctrl_i.dim_step);

  always_comb begin
    case (ctrl_i.op)
      HEAD_LOAD: nxt_o = {ctrl_i.level, ctrl_i.blue, ctrl_i.green, ctrl_i.red};
      HEAD_DIM:  nxt_o = {dim_lvl, cur_i[LED_W-LVL_W-1:0]};
      default:   nxt_o = cur_i;
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/led_strip_frame_buffer_core.sv @@
// Top level of the LED strip frame buffer: command stream in, frame words out.
`timescale 1ns / 1ps
`default_nettype none

// The LED store is a ring of MAX_LEDS cells; the first N (led_count, clamped
// to 1..MAX_LEDS) turn as a circular shift register, one place per clock,
// with an edit unit on the path from cell 0 back to cell N-1. Every command
// is carried out as a number of ring steps: set all, dim, set one and flush
// take N steps (the edit unit loads, dims or reads the passing slot), rotate
// left 1, rotate right N-1, unrotate as many steps as the offset. A command
// is accepted, its stored offset is reduced modulo N (by repeated subtraction
// of N when a stale offset exceeds a new led_count), its ring steps run, then
// one status transaction follows; an enabled flush emits instead a start word,
// N LED words, 2+N/64 end words (N+3 in all while N < 64), one per cycle while
// the output is taken; it stalls the ring when the output is held. One command
// is in flight at a time; a new one is accepted as soon as the previous one has
// handed over its last result, even while it still sits in the output register.
// Registers (APB, byte address 4*i): 0 led_count (reset 32), 1 output_enable.

module led_strip_frame_buffer_core
  import lsfb_pkg::*;
#(
  parameter int unsigned MAX_LEDS = MAX_LEDS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // command stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // led_index[5:0] red[13:6] green[21:14] blue[29:22] level[34:30] dim_step[42:35]
  input  wire logic [47:0] s_axis_tdata,
  // req_type[2:0]
  input  wire logic [2:0]  s_axis_tuser,
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // frame_word[31:0] status[33:32], zero padded
  output logic [39:0]      m_axis_tdata,
  // is_frame_word[0]
  output logic             m_axis_tuser,
  output logic             m_axis_tlast,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned CNT_W  = $clog2(MAX_LEDS + 1);
  localparam int unsigned IDX_W  = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int unsigned ENDS_W = $clog2(MAX_LEDS / 64 + 3);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_NORM  = 6'b000010,
    S_START = 6'b000100,
    S_WALK  = 6'b001000,
    S_ENDS  = 6'b010000,
    S_RESP  = 6'b100000
  } state_e;

  // ---------------------------------------------------------------- config
  logic [CFG_CNT_W-1:0] led_count_q;
  logic                 out_en_q;
  logic                 cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_count_q <= LED_COUNT_RST;
      out_en_q    <= 1'b0;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_LED_COUNT) begin
        led_count_q <= pwdata[CFG_CNT_W-1:0];
      end else begin
        out_en_q <= pwdata[0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_OUT_EN) ? {31'd0, out_en_q}
                                           : {{(32-CFG_CNT_W){1'b0}}, led_count_q};

  // active LED count, clamped to 1..MAX_LEDS
  logic [CNT_W-1:0] n_act;
  always_comb begin
    if (led_count_q == '0) begin
      n_act = CNT_W'(1);
    end else if (32'(led_count_q) > MAX_LEDS) begin
      n_act = CNT_W'(MAX_LEDS);
    end else begin
      n_act = CNT_W'(led_count_q);
    end
  end

  // ---------------------------------------------------------------- control
  state_e             state_q, state_d;
  req_e               req_q;
  logic [IDX_IN_W-1:0] idx_q;
  logic [COL_W-1:0]   red_q, green_q, blue_q, step_amt_q;
  logic [LVL_W-1:0]   lvl_q;
  logic [IDX_W-1:0]   rot_q, rot_d;     // stored rotation offset
  logic [IDX_W-1:0]   off_q, off_d;     // offset reduced modulo N
  logic [IDX_W-1:0]   tgt_q, tgt_d;     // slot hit by set one
  logic [CNT_W-1:0]   cnt_q, cnt_d;     // ring steps of this command
  logic [IDX_W-1:0]   pos_q, pos_d;     // ring step number
  logic [ENDS_W-1:0]  end_q, end_d;
  status_e            stat_q, stat_d;
  logic               flush_q, flush_d;

  // output register
  logic               out_vld_q;
  logic [WORD_W-1:0]  out_word_q;
  logic               out_isf_q;
  status_e            out_stat_q;
  logic               out_last_q;

  logic               can_emit;
  logic               emit;
  logic [WORD_W-1:0]  emit_word;
  logic               emit_isf;
  status_e            emit_stat;
  logic               emit_last;
  logic               shift_en;
  head_ctrl_t         head_ctrl;

  logic [LED_W-1:0]   cell_q [MAX_LEDS];
  logic [LED_W-1:0]   head_nxt;

  logic               in_acc;
  logic [6:0]         tgt_sum;
  logic [ENDS_W-1:0]  ends_n;
  logic               idx_ok;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign can_emit      = !out_vld_q || m_axis_tready;

  assign ends_n  = ENDS_W'(2) + ENDS_W'(n_act >> ENDS_SHIFT);
  assign tgt_sum = 7'(idx_q) - 7'd1 + 7'(off_q);
  assign idx_ok  = (idx_q != '0) && (idx_q <= IDX_IN_W'(n_act));

  always_comb begin
    state_d   = state_q;
    rot_d     = rot_q;
    off_d     = off_q;
    tgt_d     = tgt_q;
    cnt_d     = cnt_q;
    pos_d     = pos_q;
    end_d     = end_q;
    stat_d    = stat_q;
    flush_d   = flush_q;
    emit      = 1'b0;
    emit_word = '0;
    emit_isf  = 1'b0;
    emit_stat = ST_OK;
    emit_last = 1'b0;
    shift_en  = 1'b0;

    head_ctrl.level    = lvl_q;
    head_ctrl.blue     = blue_q;
    head_ctrl.green    = green_q;
    head_ctrl.red      = red_q;
    head_ctrl.dim_step = step_amt_q;
    case (req_q)
      REQ_SET_ALL: head_ctrl.op = HEAD_LOAD;
      REQ_SET_ONE: head_ctrl.op = (pos_q == tgt_q) ? HEAD_LOAD : HEAD_PASS;
      REQ_DIM:     head_ctrl.op = HEAD_DIM;
      default:     head_ctrl.op = HEAD_PASS;
    endcase

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          off_d   = rot_q;
          state_d = S_NORM;
        end
      end
      S_NORM: begin
        if (CNT_W'(off_q) >= n_act) begin
          off_d = IDX_W'(CNT_W'(off_q) - n_act);
        end else begin
          pos_d   = '0;
          end_d   = '0;
          stat_d  = ST_OK;
          flush_d = 1'b0;
          cnt_d   = '0;
          tgt_d   = (tgt_sum >= 7'(n_act)) ? IDX_W'(tgt_sum - 7'(n_act)) : IDX_W'(tgt_sum);
          case (req_q)
            REQ_SET_ONE: begin
              if (idx_ok) begin
                cnt_d = n_act;
              end else begin
                stat_d = ST_RANGE;
              end
            end
            REQ_SET_ALL, REQ_DIM: cnt_d = n_act;
            REQ_ROT_LEFT: begin
              cnt_d = CNT_W'(1);
              rot_d = (CNT_W'(off_q) + CNT_W'(1) == n_act) ? '0 : IDX_W'(off_q + 1'b1);
            end
            REQ_ROT_RGHT: begin
              cnt_d = n_act - CNT_W'(1);
              rot_d = (off_q == '0) ? IDX_W'(n_act - CNT_W'(1)) : IDX_W'(off_q - 1'b1);
            end
            REQ_UNROTATE: begin
              cnt_d = CNT_W'(off_q);
              rot_d = '0;
            end
            REQ_FLUSH: begin
              if (out_en_q) begin
                cnt_d   = n_act;
                flush_d = 1'b1;
              end else begin
                stat_d = ST_DISABLED;
              end
            end
            default: ;
          endcase
          if (flush_d) begin
            state_d = S_START;
          end else if (cnt_d != '0) begin
            state_d = S_WALK;
          end else begin
            state_d = S_RESP;
          end
        end
      end
      S_START: begin
        if (can_emit) begin
          emit     = 1'b1;
          emit_isf = 1'b1;
          state_d  = S_WALK;
        end
      end
      S_WALK: begin
        if (!flush_q || can_emit) begin
          shift_en = 1'b1;
          pos_d    = IDX_W'(pos_q + 1'b1);
          if (flush_q) begin
            emit      = 1'b1;
            emit_isf  = 1'b1;
            emit_word = {LED_HDR, cell_q[0]};
          end
          if (CNT_W'(pos_q) == cnt_q - CNT_W'(1)) begin
            state_d = flush_q ? S_ENDS : S_RESP;
          end
        end
      end
      S_ENDS: begin
        if (can_emit) begin
          emit      = 1'b1;
          emit_isf  = 1'b1;
          emit_last = (end_q == ends_n - ENDS_W'(1));
          end_d     = ENDS_W'(end_q + 1'b1);
          if (emit_last) begin
            state_d = S_IDLE;
          end
        end
      end
      S_RESP: begin
        if (can_emit) begin
          emit      = 1'b1;
          emit_stat = stat_q;
          emit_last = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      rot_q     <= '0;
      off_q     <= '0;
      tgt_q     <= '0;
      cnt_q     <= '0;
      pos_q     <= '0;
      end_q     <= '0;
      stat_q    <= ST_OK;
      flush_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rot_q   <= rot_d;
      off_q   <= off_d;
      tgt_q   <= tgt_d;
      cnt_q   <= cnt_d;
      pos_q   <= pos_d;
      end_q   <= end_d;
      stat_q  <= stat_d;
      flush_q <= flush_d;
      if (emit) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // command payload and result payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q      <= req_e'(s_axis_tuser);
      idx_q      <= s_axis_tdata[5:0];
      red_q      <= s_axis_tdata[13:6];
      green_q    <= s_axis_tdata[21:14];
      blue_q     <= s_axis_tdata[29:22];
      lvl_q      <= s_axis_tdata[34:30];
      step_amt_q <= s_axis_tdata[42:35];
    end
    if (emit) begin
      out_word_q <= emit_word;
      out_isf_q  <= emit_isf;
      out_stat_q <= emit_stat;
      out_last_q <= emit_last;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'd0, out_stat_q, out_word_q};
  assign m_axis_tuser  = out_isf_q;
  assign m_axis_tlast  = out_last_q;

  // ---------------------------------------------------------------- ring
  lsfb_head u_head (
    .cur_i  (cell_q[0]),
    .ctrl_i (head_ctrl),
    .nxt_o  (head_nxt)
  );

  for (genvar gi = 0; gi < MAX_LEDS; gi++) begin : g_cell
    logic [LED_W-1:0] nbr;
    if (gi == MAX_LEDS - 1) begin : g_end
      assign nbr = head_nxt;
    end else begin : g_mid
      assign nbr = cell_q[gi+1];
    end

    lsfb_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .shift_i  (shift_en),
      .active_i (CNT_W'(gi) < n_act),
      .tail_i   (CNT_W'(gi) == n_act - CNT_W'(1)),
      .nbr_i    (nbr),
      .wrap_i   (head_nxt),
      .q_o      (cell_q[gi])
    );
  end

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
// Self-checking testbench for the LED strip frame buffer core.
`timescale 1ns / 1ps

module testbench;
  import lsfb_pkg::*;

  // Settle time before a register write and at the end; covers a full
  // ring walk plus the worst stale offset reduction.
  localparam int unsigned SETTLE_CYCLES = 80;
  localparam int unsigned HOLD_CYCLES   = 300;

  localparam logic [2:0] ADDR_LED_COUNT = {REG_LED_COUNT, 2'b00};
  localparam logic [2:0] ADDR_OUT_EN    = {REG_OUT_EN, 2'b00};
  localparam logic [2:0] REQ_SPARE      = 3'd7;  // unused code, answers ok

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // One expected output transaction
  typedef struct packed {
    logic [31:0] word;
    logic        is_frame;
    logic [1:0]  st;
    logic        lst;
  } out_word_t;

  out_word_t pending_words[$];
  int unsigned bad_words = 0;

  // Shadow of the LED store, offset and registers
  logic [LED_W-1:0] led_mem[MAX_LEDS_DEF];
  int unsigned      rot_off;
  logic [5:0]       cfg_led_count;
  logic             cfg_out_en;

  // Idling controls, in percent
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  logic        holding = 1'b0;
  event        hold_off;

  led_strip_frame_buffer_core #(
    .MAX_LEDS(MAX_LEDS_DEF)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Receiver: random stalls, or a long hold-off when requested
  always @(posedge clk_i) begin
    if (holding) begin
      m_axis_tready <= 1'b0;
    end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Hold-off counter, own process so the sender keeps pushing meanwhile
  initial forever begin
    @(hold_off);
    holding <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    holding <= 1'b0;
  end

  // Output checker: each transaction against the oldest expectation
  always @(posedge clk_i) begin : check_results
    out_word_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_words.size() == 0) begin
        bad_words++;
        if (bad_words <= 10)
          $display("%0t: unexpected word %h frame %b st %0d last %b", $time,
                   m_axis_tdata[31:0], m_axis_tuser, m_axis_tdata[33:32], m_axis_tlast);
      end else begin
        want = pending_words.pop_front();
        if (m_axis_tdata[31:0] !== want.word || m_axis_tuser !== want.is_frame ||
            m_axis_tdata[33:32] !== want.st || m_axis_tlast !== want.lst) begin
          bad_words++;
          if (bad_words <= 10)
            $display("%0t: got %h/%b/%0d/%b, expected %h/%b/%0d/%b (word/frame/st/last)",
                     $time, m_axis_tdata[31:0], m_axis_tuser, m_axis_tdata[33:32],
                     m_axis_tlast, want.word, want.is_frame, want.st, want.lst);
        end
      end
    end
  end

  // led_count clamped to 1..MAX_LEDS
  function automatic int unsigned live_count();
    if (cfg_led_count == 0) return 1;
    if (cfg_led_count > MAX_LEDS_DEF) return MAX_LEDS_DEF;
    return 32'(cfg_led_count);
  endfunction

  function automatic void queue_word(logic [31:0] word, logic is_frame, logic [1:0] st,
                                     logic lst);
    out_word_t w;
    w.word = word;
    w.is_frame = is_frame;
    w.st = st;
    w.lst = lst;
    pending_words.push_back(w);
  endfunction

  // Updates the shadow store for one command and queues its output words
  task automatic apply_command(input logic [2:0] req, input logic [5:0] idx,
                               input logic [7:0] r, input logic [7:0] g,
                               input logic [7:0] b, input logic [4:0] lv,
                               input logic [7:0] step);
    int unsigned      n;
    int unsigned      off;
    int unsigned      ends;
    int unsigned      total;
    int unsigned      k;
    logic [1:0]       st;
    logic [4:0]       cur;
    logic [LED_W-1:0] edge_led;
    logic [LED_W-1:0] ring_copy[MAX_LEDS_DEF];
    n = live_count();
    off = rot_off % n;  // stale offset is reduced at use
    st = ST_OK;
    case (req)
      REQ_SET_ONE: begin
        if (idx >= 1 && idx <= n) led_mem[(idx - 1 + off) % n] = {lv, b, g, r};
        else st = ST_RANGE;
      end
      REQ_SET_ALL: begin
        for (int i = 0; i < n; i++) led_mem[i] = {lv, b, g, r};
      end
      REQ_DIM: begin
        for (int i = 0; i < n; i++) begin
          cur = led_mem[i][28:24];
          led_mem[i][28:24] = (step > cur) ? 5'd0 : cur - step[4:0];
        end
      end
      REQ_ROT_LEFT: begin
        edge_led = led_mem[0];
        for (int i = 0; i + 1 < n; i++) led_mem[i] = led_mem[i + 1];
        led_mem[n - 1] = edge_led;
        rot_off = (off + 1) % n;
      end
      REQ_ROT_RGHT: begin
        edge_led = led_mem[n - 1];
        for (int i = n - 1; i > 0; i--) led_mem[i] = led_mem[i - 1];
        led_mem[0] = edge_led;
        rot_off = (off + n - 1) % n;
      end
      REQ_UNROTATE: begin
        for (int i = 0; i < n; i++) ring_copy[i] = led_mem[(i + off) % n];
        for (int i = 0; i < n; i++) led_mem[i] = ring_copy[i];
        rot_off = 0;
      end
      REQ_FLUSH: begin
        if (cfg_out_en) begin
          ends = 1 + (n / 2) / 32 + 1;
          total = 1 + n + ends;
          queue_word(32'd0, 1'b1, ST_OK, total == 1);  // start word
          k = 1;
          for (int i = 0; i < n; i++) begin
            queue_word({LED_HDR, led_mem[i]}, 1'b1, ST_OK, k + 1 == total);
            k++;
          end
          for (int i = 0; i < ends; i++) begin
            queue_word(32'd0, 1'b1, ST_OK, k + 1 == total);
            k++;
          end
          return;
        end
        st = ST_DISABLED;
      end
      default: ;
    endcase
    queue_word(32'd0, 1'b0, st, 1'b1);
  endtask

  // Offers one command and waits for its acceptance; valid stays high
  // afterwards so back-to-back commands need no gap.
  task automatic send_command(input logic [2:0] req, input logic [5:0] idx,
                              input logic [7:0] r, input logic [7:0] g,
                              input logic [7:0] b, input logic [4:0] lv,
                              input logic [7:0] step);
    int unsigned gap;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      gap = ($urandom_range(7) == 0) ? $urandom_range(40, 8) : $urandom_range(4, 1);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {5'd0, step, lv, b, g, r, idx};
    do @(posedge clk_i); while (!s_axis_tready);
    apply_command(req, idx, r, g, b, lv, step);
  endtask

  // Command whose payload does not matter: random fields
  task automatic send_plain(input logic [2:0] req);
    send_command(req, 6'($urandom_range(63)), 8'($urandom_range(255)),
                 8'($urandom_range(255)), 8'($urandom_range(255)),
                 5'($urandom_range(31)), 8'($urandom_range(255)));
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // APB write: setup then access; register is taken at the access edge
  task automatic configure(input logic [2:0] addr, input logic [31:0] data);
    drain_results();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_LED_COUNT) cfg_led_count = data[5:0];
    else cfg_out_en = data[0];
  endtask

  task automatic send_random_command();
    int unsigned pick;
    logic [2:0]  req;
    logic [5:0]  idx;
    logic [7:0]  step;
    pick = $urandom_range(99);
    idx = 6'($urandom_range(63));
    // mostly small steps so levels survive a few dims
    step = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(4));
    if (pick < 30) begin
      req = REQ_SET_ONE;
      if ($urandom_range(7) != 0) idx = 6'($urandom_range(live_count(), 1));
    end else if (pick < 40) req = REQ_SET_ALL;
    else if (pick < 50) req = REQ_DIM;
    else if (pick < 60) req = REQ_ROT_LEFT;
    else if (pick < 70) req = REQ_ROT_RGHT;
    else if (pick < 77) req = REQ_UNROTATE;
    else if (pick < 95) req = REQ_FLUSH;
    else req = REQ_SPARE;
    send_command(req, idx, 8'($urandom_range(255)), 8'($urandom_range(255)),
                 8'($urandom_range(255)), 5'($urandom_range(31)), step);
  endtask

  function automatic logic [31:0] pick_led_count();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick == 0) return 32'd0;
    if (pick == 1) return $urandom_range(63, 33);
    if (pick < 5) return $urandom_range(6, 1);
    return $urandom_range(32, 1);
  endfunction

  // Reset state, extremes of every field, each command and the index limits
  task automatic test_commands();
    send_plain(REQ_FLUSH);                    // output still disabled
    configure(ADDR_OUT_EN, 32'd1);
    send_plain(REQ_FLUSH);                    // cleared store
    send_command(REQ_SET_ALL, 6'd0, 8'hFF, 8'hFF, 8'hFF, 5'd31, 8'd0);
    send_command(REQ_DIM, 6'd0, 8'd0, 8'd0, 8'd0, 5'd0, 8'd0);
    send_command(REQ_DIM, 6'd0, 8'd0, 8'd0, 8'd0, 5'd0, 8'd7);
    send_command(REQ_SET_ONE, 6'd0, 8'hFF, 8'hFF, 8'hFF, 5'd31, 8'hFF);  // index zero
    send_command(REQ_SET_ONE, 6'd33, 8'h12, 8'h34, 8'h56, 5'd9, 8'd0);   // past N
    send_command(REQ_SET_ONE, 6'd63, 8'hFF, 8'hFF, 8'hFF, 5'd31, 8'hFF);
    send_command(REQ_SET_ONE, 6'd1, 8'd0, 8'd0, 8'd0, 5'd0, 8'd0);
    send_command(REQ_SET_ONE, 6'd32, 8'hAA, 8'h55, 8'h0F, 5'd10, 8'd0);
    send_plain(REQ_ROT_LEFT);
    send_plain(REQ_ROT_LEFT);
    send_plain(REQ_ROT_RGHT);
    send_command(REQ_SET_ONE, 6'd1, 8'h11, 8'h22, 8'h33, 5'd3, 8'd0);   // through offset
    send_plain(REQ_FLUSH);
    send_plain(REQ_UNROTATE);
    send_plain(REQ_FLUSH);
    send_command(REQ_DIM, 6'd0, 8'd0, 8'd0, 8'd0, 5'd0, 8'hFF);
    send_command(REQ_SPARE, 6'h3F, 8'hFF, 8'hFF, 8'hFF, 5'd31, 8'hFF);
    send_plain(REQ_FLUSH);
  endtask

  // Chain lengths at and beyond the limits, with an offset left stale
  task automatic test_led_counts();
    send_plain(REQ_ROT_RGHT);                 // offset now N-1
    configure(ADDR_LED_COUNT, 32'd3);
    send_command(REQ_SET_ONE, 6'd3, 8'h81, 8'h42, 8'h24, 5'd17, 8'd0);
    send_plain(REQ_ROT_LEFT);
    send_plain(REQ_FLUSH);
    send_plain(REQ_UNROTATE);
    configure(ADDR_LED_COUNT, 32'd1);
    send_plain(REQ_ROT_RGHT);
    send_command(REQ_SET_ONE, 6'd2, 8'h01, 8'h02, 8'h03, 5'd4, 8'd0);   // past N
    send_plain(REQ_FLUSH);
    configure(ADDR_LED_COUNT, 32'd0);         // acts as one LED
    send_command(REQ_SET_ONE, 6'd1, 8'h7E, 8'hE7, 8'h3C, 5'd21, 8'd0);
    send_plain(REQ_FLUSH);
    configure(ADDR_LED_COUNT, 32'd63);        // acts as the full chain
    send_plain(REQ_ROT_LEFT);
    send_plain(REQ_FLUSH);
  endtask

  task automatic run_random_phase(input int unsigned send_pct, input int unsigned rx_pct,
                                  input int unsigned items);
    send_idle_pct = send_pct;
    stall_pct = rx_pct;
    // two halves so the chain length changes under a live offset
    repeat (2) begin
      configure(ADDR_LED_COUNT, pick_led_count());
      configure(ADDR_OUT_EN, {31'd0, $urandom_range(4) != 0});
      repeat (items / 2) send_random_command();
    end
  endtask

  // Long receiver hold-off while commands keep coming: input must stall
  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct = 0;
    configure(ADDR_LED_COUNT, 32'd32);
    configure(ADDR_OUT_EN, 32'd1);
    -> hold_off;
    send_plain(REQ_FLUSH);
    send_plain(REQ_FLUSH);
    repeat (12) send_random_command();
    send_plain(REQ_FLUSH);
  endtask

  initial begin
    for (int i = 0; i < MAX_LEDS_DEF; i++) led_mem[i] = '0;
    rot_off = 0;
    cfg_led_count = LED_COUNT_RST;
    cfg_out_en = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_commands();
    test_led_counts();
    run_random_phase(0, 0, 70);
    run_random_phase(46, 0, 70);
    run_random_phase(0, 46, 70);
    run_random_phase(31, 31, 70);
    test_backpressure();

    drain_results();
    if (bad_words == 0 && pending_words.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

@@ sim.f @@
hdl/lsfb_pkg.sv
hdl/lsfb_cell.sv
hdl/lsfb_head.sv
hdl/led_strip_frame_buffer_core.sv
dv/testbench.sv
